// ===== sv/rq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rq_pkg
// Shared types and defaults for the reversible queue.
// ----------------------------------------------------------------------------
package rq_pkg;

   localparam int RQ_DEPTH      = 16;
   localparam int RQ_ELEM_WIDTH = 32;

   typedef enum logic [1:0] {
      MODE_ENQ = 2'd0,
      MODE_DEQ = 2'd1,
      MODE_REV = 2'd2,
      MODE_NOP = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_DATA = 1'b1
   } state_type;

endpackage

// ===== sv/reversible_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reversible_queue_top
// Bounded queue whose front and back can be swapped, held in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one operation (enqueue, dequeue, revert, no-op) per
//   transfer; rsp_ channel returns one result per operation: the front
//   value, empty flag, element count and status after the operation.
//   In the accept cycle an operation updates the end pointers, writes the
//   slot and issues the front read; in the read stage the registered read
//   data is taken into the result register, which raises rsp_valid. No new
//   operation is accepted while one waits in the read stage. A write and a
//   read of the same slot in the accept cycle are resolved by forwarding the
//   written value.
//   Reset empties the queue and sets normal orientation; slot contents are
//   left as they are. If the receiver stalls, the result register holds its
//   item, one more operation may be accepted, and that one waits in the
//   read stage until the result register frees.
// ----------------------------------------------------------------------------
module reversible_queue_top
   import rq_pkg::*;
#(
   parameter int DEPTH      = RQ_DEPTH,
   parameter int ELEM_WIDTH = RQ_ELEM_WIDTH,
   localparam int AW        = $clog2(DEPTH),
   localparam int CW        = $clog2(DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_mode,
   input  logic signed [31:0]   req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [31:0]   rsp_front_value,
   output logic                 rsp_is_empty,
   output logic [CW-1:0]        rsp_count,
   output logic [1:0]           rsp_status
);

   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   function automatic logic [AW-1:0] idx_up(input logic [AW-1:0] i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [AW-1:0] idx_down(input logic [AW-1:0] i);
      return (i == '0) ? LAST_IDX : i - 1'b1;
   endfunction

   // slot memory
   logic [ELEM_WIDTH-1:0] slots_ff [DEPTH];
   logic [ELEM_WIDTH-1:0] rdata_ff;

   state_type             state_ff, state_in;
   logic [AW-1:0]         low_ff, low_in;
   logic [AW-1:0]         high_ff, high_in;
   logic [CW-1:0]         fill_ff, fill_in;
   logic                  rev_ff, rev_in;
   logic                  fwd_ff, fwd_in;
   logic [ELEM_WIDTH-1:0] wdata_ff;
   status_type            stat_ff, stat_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]    front_ff;
   logic                  empty_ff;
   logic [CW-1:0]         count_ff;
   status_type            rstat_ff;

   logic                  req_xfer;
   logic                  load_out;
   logic                  mem_we;
   logic [AW-1:0]         waddr;
   logic [AW-1:0]         raddr;
   logic [ELEM_WIDTH-1:0] wdata;
   logic signed [63:0]    val_ext;
   logic signed [ELEM_WIDTH-1:0] elem;
   logic signed [63:0]    elem_ext;
   mode_type              mode;

   assign mode     = mode_type'(req_mode);
   assign req_xfer = req_valid && req_ready;
   assign val_ext  = 64'(req_value);
   assign wdata    = val_ext[ELEM_WIDTH-1:0];

   // pointer update and memory addressing for the accepted operation
   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      fill_in = fill_ff;
      rev_in  = rev_ff;
      stat_in = STAT_DONE;
      mem_we  = 1'b0;
      waddr   = high_ff;
      case (mode)
         MODE_ENQ: begin
            if (fill_ff == FULL_CNT) begin
               stat_in = STAT_FULL;
            end else if (rev_ff) begin
               low_in  = idx_down(low_ff);
               waddr   = idx_down(low_ff);
               mem_we  = req_xfer;
               fill_in = fill_ff + 1'b1;
            end else begin
               waddr   = high_ff;
               high_in = idx_up(high_ff);
               mem_we  = req_xfer;
               fill_in = fill_ff + 1'b1;
            end
         end
         MODE_DEQ: begin
            if (fill_ff == '0) begin
               stat_in = STAT_EMPTY;
            end else begin
               if (rev_ff) begin
                  high_in = idx_down(high_ff);
               end else begin
                  low_in = idx_up(low_ff);
               end
               fill_in = fill_ff - 1'b1;
               // last element gone: collapse the ends
               if (fill_ff == CW'(1)) begin
                  high_in = rev_ff ? low_ff : idx_up(low_ff);
               end
            end
         end
         MODE_REV: begin
            rev_in = ~rev_ff;
         end
         default: begin
         end
      endcase
      raddr  = rev_in ? idx_down(high_in) : low_in;
      fwd_in = mem_we && (waddr == raddr);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slots_ff[waddr] <= wdata;
      end
      if (req_xfer) begin
         rdata_ff <= slots_ff[raddr];
         wdata_ff <= wdata;
         fwd_ff   <= fwd_in;
         stat_ff  <= stat_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_ready = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_DATA: begin
            load_out = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   assign elem     = fwd_ff ? wdata_ff : rdata_ff;
   assign elem_ext = 64'(elem);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         low_ff       <= '0;
         high_ff      <= '0;
         fill_ff      <= '0;
         rev_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            low_ff  <= low_in;
            high_ff <= high_in;
            fill_ff <= fill_in;
            rev_ff  <= rev_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         front_ff <= (fill_ff == '0) ? '0 : elem_ext[31:0];
         empty_ff <= (fill_ff == '0);
         count_ff <= fill_ff;
         rstat_ff <= stat_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_front_value = front_ff;
   assign rsp_is_empty    = empty_ff;
   assign rsp_count       = count_ff;
   assign rsp_status      = rstat_ff;

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_CNT)
      else $error("fill count above depth");

   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (low_ff == high_ff))
      else $error("empty queue with split ends");

   a_accept_data: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_DATA))
      else $error("accepted operation not in read stage");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rstat_ff == STAT_FULL) |-> (count_ff == FULL_CNT))
      else $error("full status with room left");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (empty_ff == (count_ff == '0)))
      else $error("empty flag disagrees with count");
`endif

endmodule
